FILE: hdl/ghsp_pkg.sv
// Shared types and constants of the generational handle slot pool.
`default_nettype none
package ghsp_pkg;

   // Field widths
   localparam int GEN_W    = 32;
   localparam int LOW_W    = 32;
   localparam int HANDLE_W = GEN_W + LOW_W;
   localparam int STATUS_W = 2;

   // Defaults for the top-level parameters
   localparam int NUM_SLOTS_DEF  = 256;
   localparam int INDEX_BIAS_DEF = 1;

   // Command codes
   typedef enum logic {
      CMD_ALLOC   = 1'b0,
      CMD_RELEASE = 1'b1
   } cmd_type;

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK   = 2'd0,
      ST_FULL = 2'd1,
      ST_BAD  = 2'd2
   } status_type;

endpackage
`default_nettype wire

FILE: hdl/ghsp_req_if.sv
// Command channel: valid/ready with command code and handle.
`default_nettype none
interface ghsp_req_if;
   import ghsp_pkg::*;

   logic                valid;
   logic                ready;
   logic                cmd;
   logic [HANDLE_W-1:0] handle;

   modport source (output valid, output cmd, output handle, input ready);
   modport sink   (input valid, input cmd, input handle, output ready);
endinterface
`default_nettype wire

FILE: hdl/ghsp_rsp_if.sv
// Result channel: valid/ready with status and new handle.
`default_nettype none
interface ghsp_rsp_if;
   import ghsp_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [HANDLE_W-1:0] new_handle;

   modport source (output valid, output status, output new_handle, input ready);
   modport sink   (input valid, input status, input new_handle, output ready);
endinterface
`default_nettype wire

FILE: hdl/ghsp_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
`default_nettype none
module ghsp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, data held while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule
`default_nettype wire

FILE: hdl/generational_handle_slot_pool_core.sv
// Top level of the generational handle slot pool: sequencer, counters, result register.
//
//   channel  | direction | transfer when      | payload
//   ---------+-----------+--------------------+---------------------------
//   req      | in        | req.valid & ready  | cmd, handle
//   rsp      | out       | rsp.valid & ready  | status, new_handle
//
// A release or a fresh allocate goes accept/read (S_IDLE), then modify/write
// (S_RMW); an allocate that pops the free stack passes S_POP in between, as
// the stack read must complete before the slot memory read. A full pool or
// bad handle goes S_IDLE then S_RMW. One slot read port paces each command.
// Synchronous reset clears counters and control; both memories need no clear,
// since slots at or above the high-water mark read as zero.
// A pending result in the output register does not block acceptance; the
// write-back stage waits only if the previous result has not yet been taken.
`default_nettype none
module generational_handle_slot_pool_core #(
   parameter int NUM_SLOTS  = ghsp_pkg::NUM_SLOTS_DEF,
   parameter int INDEX_BIAS = ghsp_pkg::INDEX_BIAS_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   ghsp_req_if.sink  req,
   ghsp_rsp_if.source rsp
);
   import ghsp_pkg::*;

   localparam int IDX_W  = $clog2(NUM_SLOTS);
   localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
   localparam int SLOT_W = GEN_W + 1;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_POP  = 3'b010,
      S_RMW  = 3'b100
   } state_type;

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    fc_ff, fc_in;
   logic [CNT_W-1:0]    hw_ff, hw_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [GEN_W-1:0]    gen_chk_ff, gen_chk_in;
   logic                rel_ff, rel_in;
   logic                fresh_ff, fresh_in;
   status_type          pend_ff, pend_in;
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [HANDLE_W-1:0] rsp_handle_ff, rsp_handle_in;

   // memory ports
   logic              slot_wr_en, slot_rd_en;
   logic [IDX_W-1:0]  slot_rd_addr;
   logic [SLOT_W-1:0] slot_wr_data, slot_rd_data;
   logic              stk_wr_en, stk_rd_en;
   logic [IDX_W-1:0]  stk_wr_addr, stk_rd_addr, stk_rd_data;

   // decode helpers
   logic              accept;
   logic [LOW_W-1:0]  raw, idx32;
   logic              handle_ok;
   logic [CNT_W-1:0]  fc_m1;
   logic [GEN_W-1:0]  cur_gen, alloc_gen, inc_gen, rel_gen;
   logic              cur_act, rel_ok, can_commit;

   ghsp_ram #(.WIDTH(SLOT_W), .DEPTH(NUM_SLOTS)) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_wr_en),
      .wr_addr (idx_ff),
      .wr_data (slot_wr_data),
      .rd_en   (slot_rd_en),
      .rd_addr (slot_rd_addr),
      .rd_data (slot_rd_data)
   );

   ghsp_ram #(.WIDTH(IDX_W), .DEPTH(NUM_SLOTS)) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_wr_en),
      .wr_addr (stk_wr_addr),
      .wr_data (idx_ff),
      .rd_en   (stk_rd_en),
      .rd_addr (stk_rd_addr),
      .rd_data (stk_rd_data)
   );

   assign req.ready      = (state_ff == S_IDLE);
   assign accept         = req.valid && req.ready;
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.status     = rsp_status_ff;
   assign rsp.new_handle = rsp_handle_ff;

   // release handle check against bias and high-water mark
   assign raw       = req.handle[LOW_W-1:0];
   assign idx32     = raw - LOW_W'(INDEX_BIAS);
   assign handle_ok = (req.handle != '0) && (raw >= LOW_W'(INDEX_BIAS))
                      && (idx32 < LOW_W'(hw_ff));
   assign fc_m1     = fc_ff - CNT_W'(1);

   // slot contents; entries never taken read as zero
   assign cur_gen   = fresh_ff ? '0 : slot_rd_data[GEN_W-1:0];
   assign cur_act   = fresh_ff ? 1'b0 : slot_rd_data[GEN_W];
   assign alloc_gen = (cur_gen == '0) ? GEN_W'(1) : cur_gen;
   assign inc_gen   = cur_gen + GEN_W'(1);
   assign rel_gen   = (inc_gen == '0) ? GEN_W'(1) : inc_gen;
   assign rel_ok    = cur_act && (cur_gen == gen_chk_ff);
   assign can_commit = !rsp_valid_ff || rsp.ready;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      fc_in         = fc_ff;
      hw_in         = hw_ff;
      idx_in        = idx_ff;
      gen_chk_in    = gen_chk_ff;
      rel_in        = rel_ff;
      fresh_in      = fresh_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_handle_in = rsp_handle_ff;
      slot_rd_en    = 1'b0;
      slot_rd_addr  = idx32[IDX_W-1:0];
      slot_wr_en    = 1'b0;
      slot_wr_data  = {1'b1, alloc_gen};
      stk_rd_en     = 1'b0;
      stk_rd_addr   = fc_m1[IDX_W-1:0];
      stk_wr_en     = 1'b0;
      stk_wr_addr   = fc_ff[IDX_W-1:0];

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               fresh_in = 1'b0;
               state_in = S_RMW;
               if (req.cmd == CMD_RELEASE) begin
                  rel_in     = 1'b1;
                  gen_chk_in = req.handle[HANDLE_W-1:LOW_W];
                  idx_in     = idx32[IDX_W-1:0];
                  pend_in    = handle_ok ? ST_OK : ST_BAD;
                  slot_rd_en = handle_ok;
               end else begin
                  rel_in = 1'b0;
                  if (fc_ff != '0) begin
                     // pop most recently freed slot
                     stk_rd_en = 1'b1;
                     fc_in     = fc_m1;
                     pend_in   = ST_OK;
                     state_in  = S_POP;
                  end else if (hw_ff < CNT_W'(NUM_SLOTS)) begin
                     // take the next never-used slot
                     idx_in   = hw_ff[IDX_W-1:0];
                     fresh_in = 1'b1;
                     hw_in    = hw_ff + CNT_W'(1);
                     pend_in  = ST_OK;
                  end else begin
                     pend_in = ST_FULL;
                  end
               end
            end
         end
         S_POP: begin
            idx_in       = stk_rd_data;
            slot_rd_en   = 1'b1;
            slot_rd_addr = stk_rd_data;
            state_in     = S_RMW;
         end
         S_RMW: begin
            if (can_commit) begin
               rsp_valid_in  = 1'b1;
               rsp_handle_in = '0;
               state_in      = S_IDLE;
               if (pend_ff != ST_OK) begin
                  rsp_status_in = pend_ff;
               end else if (!rel_ff) begin
                  slot_wr_en    = 1'b1;
                  slot_wr_data  = {1'b1, alloc_gen};
                  rsp_status_in = ST_OK;
                  rsp_handle_in = {alloc_gen, LOW_W'(idx_ff) + LOW_W'(INDEX_BIAS)};
               end else if (rel_ok) begin
                  slot_wr_en    = 1'b1;
                  slot_wr_data  = {1'b0, rel_gen};
                  rsp_status_in = ST_OK;
                  if (fc_ff < CNT_W'(NUM_SLOTS)) begin
                     stk_wr_en = 1'b1;
                     fc_in     = fc_ff + CNT_W'(1);
                  end
               end else begin
                  rsp_status_in = ST_BAD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fc_ff        <= '0;
         hw_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fc_ff        <= fc_in;
         hw_ff        <= hw_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      gen_chk_ff    <= gen_chk_in;
      rel_ff        <= rel_in;
      fresh_ff      <= fresh_in;
      pend_ff       <= pend_in;
      rsp_status_ff <= rsp_status_in;
      rsp_handle_ff <= rsp_handle_in;
   end
endmodule
`default_nettype wire
